// ===== design/tps_pkg.sv =====
// Shared constants and types for the two-tap pitch shifter.
// No dependencies; every module of the block imports this package.
`default_nettype none

package tps_pkg;

    // Width of the signed per-sample delay increment register.
    localparam int INC_WIDTH = 8;

    typedef logic signed [INC_WIDTH-1:0] inc_t;

endpackage

`default_nettype wire

// ===== design/two_tap_pitch_shifter.sv =====
// Two-tap pitch shifter top level. A request passes through the front-end store read, the
// weighting registers, the divider's fold stages and final compare, and the output register.
// Throughput is one sample per cycle unless m_tready stalls the output: every stage, including the
// store with one write and two reads per cycle, is fully pipelined. Reset (rst_n, asynchronous)
// clears the pipeline and write position and sets the delays to zero and half the span; no clearing
// pass is needed, since unwritten store entries are tracked by the write position and read as zero.
`default_nettype none

module two_tap_pitch_shifter import tps_pkg::*;
#(
    parameter int DEPTH_LOG2   = 10,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Input sample stream.
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,  // sample_in, zero padded
    // Output sample stream.
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          m_tdata,  // sample_out, zero padded
    // Delay increment register write.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [INC_WIDTH-1:0]                  cfg_data  // delay_increment
);

    localparam int TW = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int DW = DEPTH_LOG2 + 2;
    localparam int AW = SAMPLE_WIDTH + DEPTH_LOG2;

    // Front end to weighting.
    logic                           f_valid;
    logic                           f_ready;
    logic signed [SAMPLE_WIDTH-1:0] f_sample1;
    logic signed [SAMPLE_WIDTH-1:0] f_sample2;
    logic [DW-1:0]                  f_weight1;
    logic [DW-1:0]                  f_weight2;

    // Weighting to divider.
    logic                           w_valid;
    logic                           w_ready;
    logic [AW-1:0]                  w_mag;
    logic                           w_neg;

    logic [SAMPLE_WIDTH-1:0]        out_sample;

    // The increment register is always writable; it only takes effect on the next
    // request, so a write while the block is idle is seen by every later sample.
    assign cfg_ready = 1'b1;

    // The front end owns all sample state. Both delays and the write position move on
    // every accepted request, independent of the data, so requests can follow each
    // other in consecutive cycles; the store reads for a request see every earlier
    // write because writes land on the accept edge before the next request's reads.
    tps_front #(
        .DEPTH_LOG2   (DEPTH_LOG2),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (inc_t'(cfg_data)),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_sample   ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_sample1 (f_sample1),
        .out_sample2 (f_sample2),
        .out_weight1 (f_weight1),
        .out_weight2 (f_weight2)
    );

    // Products of each tap with its crossfade weight, their sum, and the magnitude,
    // clamped to the point where the quotient is known to saturate.
    tps_mac #(
        .DEPTH_LOG2   (DEPTH_LOG2),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (f_valid),
        .in_ready   (f_ready),
        .in_sample1 (f_sample1),
        .in_sample2 (f_sample2),
        .in_weight1 (f_weight1),
        .in_weight2 (f_weight2),
        .out_valid  (w_valid),
        .out_ready  (w_ready),
        .out_mag    (w_mag),
        .out_neg    (w_neg)
    );

    // Truncating division by 2N-1 as a pipeline of fold steps, then the sign and the
    // saturation. Its last stage is the output register, so a result waiting on
    // m_tready does not stop new requests while the pipeline has empty stages.
    tps_div #(
        .DEPTH_LOG2   (DEPTH_LOG2),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (w_valid),
        .in_ready   (w_ready),
        .in_mag     (w_mag),
        .in_neg     (w_neg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (out_sample)
    );

    assign m_tdata = TW'(out_sample);

endmodule

`default_nettype wire

// ===== design/tps_front.sv =====
// Front end: sample store, write position, both delays, tap addresses and weights.
// Depends on tps_pkg for the increment type.
`default_nettype none

module tps_front import tps_pkg::*;
#(
    parameter int DEPTH_LOG2   = 10,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire inc_t                                 cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       in_sample,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]            out_sample1,
    output logic signed [SAMPLE_WIDTH-1:0]            out_sample2,
    output logic [DEPTH_LOG2+1:0]                     out_weight1,
    output logic [DEPTH_LOG2+1:0]                     out_weight2
);

    localparam int N  = 1 << DEPTH_LOG2;
    localparam int DW = DEPTH_LOG2 + 2;
    localparam int EW = ((DW > INC_WIDTH) ? DW : INC_WIDTH) + 2;
    localparam logic [DW-1:0]        HALF_SPAN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [EW-1:0] SPAN      = EW'(1) << DW;

    logic signed [SAMPLE_WIDTH-1:0] mem [0:N-1];

    inc_t                           inc_reg;
    logic [DEPTH_LOG2-1:0]          wp_reg;
    logic                           wrap_reg;
    logic [DW-1:0]                  d1_reg;
    logic [DW-1:0]                  d2_reg;
    logic                           vld_reg;
    logic                           hit1_reg;
    logic                           hit2_reg;
    logic [DW-1:0]                  w1_reg;
    logic [DW-1:0]                  w2_reg;
    logic signed [SAMPLE_WIDTH-1:0] rd1_reg;
    logic signed [SAMPLE_WIDTH-1:0] rd2_reg;

    logic                  accept;
    logic [DEPTH_LOG2-1:0] wp_next;
    logic [DEPTH_LOG2-1:0] idx1;
    logic [DEPTH_LOG2-1:0] idx2;
    logic                  hit1;
    logic                  hit2;

    // Triangular crossfade weight: rises over the first half of the span, falls over
    // the second. For the upper half, 4N - d is the two's complement of d in DW bits.
    function automatic logic [DW-1:0] tap_weight(input logic [DW-1:0] d);
        logic [DW-1:0] w;
        w = d[DW-1] ? DW'(~d + 1'b1) : d;
        return w;
    endfunction

    // Delay sweep: a delay that falls below zero jumps to the top of the span, one
    // that reaches the span wraps to zero.
    function automatic logic [DW-1:0] delay_step(input logic [DW-1:0] d, input inc_t inc);
        logic signed [EW-1:0] s;
        logic [DW-1:0]        r;
        s = $signed({{(EW-DW){1'b0}}, d}) + EW'(inc);
        if (s < 0)
        begin
            r = '1;
        end
        else if (s >= SPAN)
        begin
            r = '0;
        end
        else
        begin
            r = s[DW-1:0];
        end
        return r;
    endfunction

    assign in_ready = !vld_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign wp_next  = wp_reg + 1'b1;
    assign idx1     = wp_reg - d1_reg[DW-1:2];
    assign idx2     = wp_reg - d2_reg[DW-1:2];

    // Entries are written in address order starting at one, so an entry holds data
    // once the write position has passed it or the store has wrapped once.
    assign hit1 = wrap_reg || ((idx1 != '0) && (idx1 <= wp_reg));
    assign hit2 = wrap_reg || ((idx2 != '0) && (idx2 <= wp_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg  <= '0;
            wp_reg   <= '0;
            wrap_reg <= 1'b0;
            d1_reg   <= '0;
            d2_reg   <= HALF_SPAN;
            vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                inc_reg <= cfg_data;
            end
            if (in_ready)
            begin
                vld_reg <= in_valid;
            end
            if (accept)
            begin
                wp_reg <= wp_next;
                d1_reg <= delay_step(d1_reg, inc_reg);
                d2_reg <= delay_step(d2_reg, inc_reg);
                if (wp_next == '0)
                begin
                    wrap_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit1_reg <= hit1;
            hit2_reg <= hit2;
            w1_reg   <= tap_weight(d1_reg);
            w2_reg   <= tap_weight(d2_reg);
        end
    end

    // Store: one write and two registered reads per request; a read of the address
    // being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wp_next] <= in_sample;
            rd1_reg      <= mem[idx1];
            rd2_reg      <= mem[idx2];
        end
    end

    assign out_valid   = vld_reg;
    assign out_sample1 = hit1_reg ? rd1_reg : '0;
    assign out_sample2 = hit2_reg ? rd2_reg : '0;
    assign out_weight1 = w1_reg;
    assign out_weight2 = w2_reg;

endmodule

`default_nettype wire

// ===== design/tps_mac.sv =====
// Weighting: both tap products, their sum, then magnitude and clamp for the divider.
// Depends on tps_pkg by house convention; no submodules.
`default_nettype none

module tps_mac import tps_pkg::*;
#(
    parameter int DEPTH_LOG2   = 10,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]         in_sample1,
    input  wire logic signed [SAMPLE_WIDTH-1:0]         in_sample2,
    input  wire logic [DEPTH_LOG2+1:0]                  in_weight1,
    input  wire logic [DEPTH_LOG2+1:0]                  in_weight2,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [SAMPLE_WIDTH+DEPTH_LOG2-1:0]          out_mag,
    output logic                                        out_neg
);

    localparam int DW = DEPTH_LOG2 + 2;
    localparam int PW = SAMPLE_WIDTH + DW;
    localparam int SW = PW + 1;
    localparam int AW = SAMPLE_WIDTH + DEPTH_LOG2;
    // Smallest magnitude whose quotient by 2N-1 is exactly 2^(SAMPLE_WIDTH-1); anything
    // above saturates, so clamping here keeps the divider narrow.
    localparam logic [AW-1:0] LIMIT = AW'(0) - (AW'(1) << (SAMPLE_WIDTH - 1));

    logic                 va_reg;
    logic                 vb_reg;
    logic                 vc_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic signed [SW-1:0] sum_reg;
    logic [AW-1:0]        mag_reg;
    logic                 neg_reg;

    logic                 rdy_a;
    logic                 rdy_b;
    logic                 rdy_c;
    logic signed [SW-1:0] mag_full;

    assign rdy_c    = !vc_reg || out_ready;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    assign mag_full = sum_reg[SW-1] ? -sum_reg : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= in_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
            if (rdy_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            p1_reg <= in_sample1 * $signed({1'b0, in_weight1});
            p2_reg <= in_sample2 * $signed({1'b0, in_weight2});
        end
        if (rdy_b)
        begin
            sum_reg <= SW'(p1_reg) + SW'(p2_reg);
        end
        if (rdy_c)
        begin
            neg_reg <= sum_reg[SW-1];
            if ($unsigned(mag_full) > SW'(LIMIT))
            begin
                mag_reg <= LIMIT;
            end
            else
            begin
                mag_reg <= mag_full[AW-1:0];
            end
        end
    end

    assign out_valid = vc_reg;
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;

endmodule

`default_nettype wire

// ===== design/tps_div.sv =====
// Division of the clamped magnitude by 2N-1, sign restore and saturation.
// Depends on tps_pkg by house convention; no submodules.
`default_nettype none

module tps_div import tps_pkg::*;
#(
    parameter int DEPTH_LOG2   = 10,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [SAMPLE_WIDTH+DEPTH_LOG2-1:0]    in_mag,
    input  wire logic                                  in_neg,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [SAMPLE_WIDTH-1:0]                    out_sample
);

    localparam int K    = DEPTH_LOG2 + 1;
    localparam int AW   = SAMPLE_WIDTH + DEPTH_LOG2;
    localparam int SW   = SAMPLE_WIDTH;
    // Each folding step shrinks the remainder by about K-1 bits; two more steps bring
    // it to at most 2^K, where a single compare finishes the quotient.
    localparam int ITER = (AW + K - 2) / (K - 1) + 2;
    localparam logic [AW-1:0] DIVISOR = (AW'(1) << K) - AW'(1);
    localparam logic [AW-1:0] LOW_MASK = DIVISOR;
    localparam logic [SW-1:0] SAT_MAX  = {1'b0, {(SW-1){1'b1}}};

    logic          v_reg   [0:ITER-1];
    logic [SW-1:0] q_reg   [0:ITER-1];
    logic [AW-1:0] r_reg   [0:ITER-1];
    logic          neg_reg [0:ITER-1];
    logic          vf_reg;
    logic [SW-1:0] qf_reg;
    logic          negf_reg;
    logic          vo_reg;
    logic [SW-1:0] out_reg;

    logic          rdy      [0:ITER-1];
    logic [SW-1:0] q_src    [0:ITER-1];
    logic [AW-1:0] r_src    [0:ITER-1];
    logic          neg_src  [0:ITER-1];
    logic          v_src    [0:ITER-1];
    logic [SW-1:0] q_step   [0:ITER-1];
    logic [AW-1:0] r_step   [0:ITER-1];
    logic          rdy_f;
    logic          rdy_o;

    assign rdy_o    = !vo_reg || out_ready;
    assign rdy_f    = !vf_reg || rdy_o;
    assign in_ready = rdy[0];

    // Each step keeps mag = q * (2^K - 1) + r and folds the bits of r above K back
    // into the low part, since 2^K is one more than the divisor.
    always_comb
    begin
        for (int i = 0; i < ITER; i++)
        begin
            if (i == 0)
            begin
                q_src[i]   = '0;
                r_src[i]   = in_mag;
                neg_src[i] = in_neg;
                v_src[i]   = in_valid;
            end
            else
            begin
                q_src[i]   = q_reg[i-1];
                r_src[i]   = r_reg[i-1];
                neg_src[i] = neg_reg[i-1];
                v_src[i]   = v_reg[i-1];
            end
            q_step[i] = q_src[i] + SW'(r_src[i] >> K);
            r_step[i] = (r_src[i] & LOW_MASK) + (r_src[i] >> K);
        end
    end

    // Ready runs backward from the output, so the chain is built from the last stage.
    always_comb
    begin
        for (int i = ITER - 1; i >= 0; i--)
        begin
            if (i == ITER - 1)
            begin
                rdy[i] = !v_reg[i] || rdy_f;
            end
            else
            begin
                rdy[i] = !v_reg[i] || rdy[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ITER; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            vf_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < ITER; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_src[i];
                end
            end
            if (rdy_f)
            begin
                vf_reg <= v_reg[ITER-1];
            end
            if (rdy_o)
            begin
                vo_reg <= vf_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ITER; i++)
        begin
            if (rdy[i])
            begin
                q_reg[i]   <= q_step[i];
                r_reg[i]   <= r_step[i];
                neg_reg[i] <= neg_src[i];
            end
        end
        if (rdy_f)
        begin
            negf_reg <= neg_reg[ITER-1];
            if (r_reg[ITER-1] >= DIVISOR)
            begin
                qf_reg <= q_reg[ITER-1] + 1'b1;
            end
            else
            begin
                qf_reg <= q_reg[ITER-1];
            end
        end
        if (rdy_o)
        begin
            // The quotient never exceeds 2^(SW-1): negated it is the most negative
            // sample, positive it saturates to the largest one.
            if (negf_reg)
            begin
                out_reg <= SW'(~qf_reg + 1'b1);
            end
            else if (qf_reg[SW-1])
            begin
                out_reg <= SAT_MAX;
            end
            else
            begin
                out_reg <= qf_reg;
            end
        end
    end

    assign out_valid  = vo_reg;
    assign out_sample = out_reg;

endmodule

`default_nettype wire
